>>> rtl/ascii_matrix_text_parser_core_macros.svh
// Assertion macros shared by the matrix text parser RTL.
`ifndef ASCII_MATRIX_TEXT_PARSER_CORE_MACROS_SVH
`define ASCII_MATRIX_TEXT_PARSER_CORE_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define AMTP_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds.
`define AMTP_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

>>> rtl/amtp_pkg.sv
// Shared types, constants and helpers of the matrix text parser.
package amtp_pkg;

  localparam int CHAR_LIMIT_DEF = 4096;
  localparam int DIM_W          = 12;
  localparam int VALUE_W        = 32;
  localparam int TOKQ_DEPTH     = 2;
  localparam int OUTQ_DEPTH     = 4;

  localparam logic [DIM_W-1:0] DIM_MAX = '1;

  typedef enum logic [2:0] {
    TOK_DIGIT,
    TOK_MINUS,
    TOK_SPACE,
    TOK_NEWLINE,
    TOK_OTHER,
    TOK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  localparam logic RK_ELEMENT = 1'b0;
  localparam logic RK_STATUS  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               mat;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic [DIM_W-1:0]   inner;
    status_t            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [$clog2(OUTQ_DEPTH):0] level;
  } outq_stat_t;

  function automatic logic [DIM_W-1:0] sat_inc(input logic [DIM_W-1:0] v);
    return (v == DIM_MAX) ? DIM_MAX : v + DIM_W'(1);
  endfunction

endpackage

>>> rtl/amtp_front.sv
// Front end: classify input bytes and queue the resulting tokens.
module amtp_front
  import amtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output logic       tok_valid,
  output token_t     tok,
  input  logic       tok_pop
);

  localparam int PW = (TOKQ_DEPTH > 1) ? $clog2(TOKQ_DEPTH) : 1;

  token_t          slots [TOKQ_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     level;
  logic            push_fire;
  token_t          tok_in;

  // Classify the incoming byte.
  always_comb begin
    tok_in.digit = char_byte[3:0];
    if (end_of_input) begin
      tok_in.kind = TOK_END;
    end else if (char_byte inside {[8'd48:8'd57]}) begin
      tok_in.kind = TOK_DIGIT;
    end else if (char_byte == 8'd45) begin
      tok_in.kind = TOK_MINUS;
    end else if (char_byte == 8'd32) begin
      tok_in.kind = TOK_SPACE;
    end else if (char_byte == 8'd10) begin
      tok_in.kind = TOK_NEWLINE;
    end else begin
      tok_in.kind = TOK_OTHER;
    end
  end

  assign full      = (level == (PW+1)'(TOKQ_DEPTH));
  assign push_fire = push && !full;
  assign tok_valid = (level != '0);
  assign tok       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push_fire) begin
        wptr <= (wptr == PW'(TOKQ_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (tok_pop) begin
        rptr <= (rptr == PW'(TOKQ_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      level <= level + (PW+1)'(push_fire) - (PW+1)'(tok_pop);
    end
  end

endmodule

>>> rtl/amtp_exec.sv
// Back end: run the parser state on each token and form result transactions.
module amtp_exec
  import amtp_pkg::*;
#(
  parameter int CHAR_LIMIT = CHAR_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       tok_valid,
  input  token_t     tok,
  output logic       tok_pop,
  input  outq_stat_t outq_stat,
  output logic [1:0] wr_count,
  output result_t    wr_data0,
  output result_t    wr_data1
);

  localparam int BW = $clog2(CHAR_LIMIT);
  localparam logic [BW-1:0] BYTE_LAST = BW'(CHAR_LIMIT - 1);

  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic               negative_flag, negative_flag_next;
  logic               have_digits, have_digits_next;
  logic               second_matrix, second_matrix_next;
  logic               prev_newline, prev_newline_next;
  logic [DIM_W-1:0]   cur_row, cur_row_next;
  logic [DIM_W-1:0]   cur_col, cur_col_next;
  logic [DIM_W-1:0]   first_cols, first_cols_next;
  logic [DIM_W-1:0]   first_rows, first_rows_next;
  logic [DIM_W-1:0]   second_cols, second_cols_next;
  logic [DIM_W-1:0]   second_rows, second_rows_next;
  logic [BW-1:0]      byte_count, byte_count_next;
  status_t            error_state, error_state_next;

  logic    fire;
  result_t elem;
  result_t report;

  // Room for two results is needed before taking a token.
  assign fire    = tok_valid &&
                   (outq_stat.level <= ($clog2(OUTQ_DEPTH)+1)'(OUTQ_DEPTH - 2));
  assign tok_pop = fire;

  always_comb begin
    elem        = '0;
    elem.kind   = RK_ELEMENT;
    elem.mat    = second_matrix;
    elem.row    = cur_row;
    elem.col    = cur_col;
    elem.value  = negative_flag ? (VALUE_W'(0) - accumulator) : accumulator;
    elem.status = ST_OK;
    elem.last   = 1'b1;

    report       = '0;
    report.kind  = RK_STATUS;
    report.row   = first_rows;
    report.col   = second_cols;
    report.inner = first_cols;
    report.last  = 1'b1;
    if (error_state != ST_OK) begin
      report.status = error_state;
    end else if (first_cols != second_rows) begin
      report.status = ST_MISMATCH;
    end else begin
      report.status = ST_OK;
    end
  end

  always_comb begin
    accumulator_next   = accumulator;
    negative_flag_next = negative_flag;
    have_digits_next   = have_digits;
    second_matrix_next = second_matrix;
    prev_newline_next  = prev_newline;
    cur_row_next       = cur_row;
    cur_col_next       = cur_col;
    first_cols_next    = first_cols;
    first_rows_next    = first_rows;
    second_cols_next   = second_cols;
    second_rows_next   = second_rows;
    byte_count_next    = byte_count;
    error_state_next   = error_state;
    wr_count           = 2'd0;
    wr_data0           = elem;
    wr_data1           = report;

    if (fire) begin
      if (tok.kind == TOK_END) begin
        // Flush a trailing number, report, then start afresh.
        if (error_state == ST_OK && have_digits) begin
          wr_data0      = elem;
          wr_data0.last = 1'b0;
          wr_data1      = report;
          wr_count      = 2'd2;
        end else begin
          wr_data0 = report;
          wr_count = 2'd1;
        end
        accumulator_next   = '0;
        negative_flag_next = 1'b0;
        have_digits_next   = 1'b0;
        second_matrix_next = 1'b0;
        prev_newline_next  = 1'b0;
        cur_row_next       = '0;
        cur_col_next       = '0;
        first_cols_next    = '0;
        first_rows_next    = '0;
        second_cols_next   = '0;
        second_rows_next   = '0;
        byte_count_next    = '0;
        error_state_next   = ST_OK;
      end else if (error_state != ST_OK) begin
        // Drop characters after an error.
      end else if (byte_count >= BYTE_LAST) begin
        error_state_next = ST_TOO_MANY;
      end else begin
        byte_count_next = byte_count + BW'(1);
        case (tok.kind)
          TOK_DIGIT: begin
            accumulator_next = (accumulator << 3) + (accumulator << 1)
                               + VALUE_W'(tok.digit);
            have_digits_next  = 1'b1;
            prev_newline_next = 1'b0;
          end
          TOK_MINUS: begin
            negative_flag_next = 1'b1;
            prev_newline_next  = 1'b0;
          end
          TOK_SPACE: begin
            wr_count           = have_digits ? 2'd1 : 2'd0;
            accumulator_next   = '0;
            negative_flag_next = 1'b0;
            have_digits_next   = 1'b0;
            if (!second_matrix && first_rows == '0) begin
              first_cols_next = sat_inc(first_cols);
            end
            if (second_matrix && second_rows == '0) begin
              second_cols_next = sat_inc(second_cols);
            end
            cur_col_next      = sat_inc(cur_col);
            prev_newline_next = 1'b0;
          end
          TOK_NEWLINE: begin
            accumulator_next   = '0;
            negative_flag_next = 1'b0;
            have_digits_next   = 1'b0;
            prev_newline_next  = !prev_newline;
            if (prev_newline) begin
              // Blank line: move on to matrix B once.
              if (!second_matrix) begin
                second_matrix_next = 1'b1;
                cur_row_next       = '0;
                cur_col_next       = '0;
              end
            end else begin
              wr_count = have_digits ? 2'd1 : 2'd0;
              if (!second_matrix) begin
                if (first_rows == '0) begin
                  first_cols_next = sat_inc(first_cols);
                end
                first_rows_next = sat_inc(first_rows);
              end else begin
                if (second_rows == '0) begin
                  second_cols_next = sat_inc(second_cols);
                end
                second_rows_next = sat_inc(second_rows);
              end
              cur_row_next = sat_inc(cur_row);
              cur_col_next = '0;
            end
          end
          default: begin
            byte_count_next  = byte_count;
            error_state_next = ST_INVALID;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      negative_flag <= 1'b0;
      have_digits   <= 1'b0;
      second_matrix <= 1'b0;
      prev_newline  <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      first_cols    <= '0;
      first_rows    <= '0;
      second_cols   <= '0;
      second_rows   <= '0;
      byte_count    <= '0;
      error_state   <= ST_OK;
    end else begin
      accumulator   <= accumulator_next;
      negative_flag <= negative_flag_next;
      have_digits   <= have_digits_next;
      second_matrix <= second_matrix_next;
      prev_newline  <= prev_newline_next;
      cur_row       <= cur_row_next;
      cur_col       <= cur_col_next;
      first_cols    <= first_cols_next;
      first_rows    <= first_rows_next;
      second_cols   <= second_cols_next;
      second_rows   <= second_rows_next;
      byte_count    <= byte_count_next;
      error_state   <= error_state_next;
    end
  end

endmodule

>>> rtl/amtp_outq.sv
// Result queue: takes up to two results a cycle, hands out one.
module amtp_outq
  import amtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_count,
  input  result_t    wr_data0,
  input  result_t    wr_data1,
  input  logic       pop,
  output logic       empty,
  output result_t    rd_data,
  output outq_stat_t stat
);

  localparam int PW = $clog2(OUTQ_DEPTH);

  result_t       slots [OUTQ_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   level;
  logic          pop_fire;

  assign empty      = (level == '0);
  assign pop_fire   = pop && !empty;
  assign rd_data    = slots[rptr];
  assign stat.level = level;

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      slots[wptr] <= wr_data0;
    end
    if (wr_count == 2'd2) begin
      slots[wptr + PW'(1)] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + PW'(wr_count);
      if (pop_fire) begin
        rptr <= rptr + PW'(1);
      end
      level <= level + (PW+1)'(wr_count) - (PW+1)'(pop_fire);
    end
  end

endmodule

>>> rtl/ascii_matrix_text_parser_core.sv
// Path: a byte is registered in the token queue, its result in the result queue.
// Throughput: one byte per cycle while the result queue has room for two results.
// End of input with a pending number and no error yields two results, drained one per pop.
// Reset: synchronous, active high rst empties both queues and clears all parser state.
// No clearing pass: the block accepts bytes in the first cycle after reset.
// Top level of the ASCII matrix text parser.
`include "ascii_matrix_text_parser_core_macros.svh"

module ascii_matrix_text_parser_core
  import amtp_pkg::*;
#(
  parameter int CHAR_LIMIT = CHAR_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input side: a queue that takes one character transaction per push.
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                char_byte,
  input  logic                      end_of_input,
  // Result side: the oldest result sits on the ports while empty is low.
  output logic                      empty,
  input  logic                      pop,
  output logic                      result_kind,
  output logic                      matrix_select,
  output logic [DIM_W-1:0]          row_index,
  output logic [DIM_W-1:0]          col_index,
  output logic signed [VALUE_W-1:0] elem_value,
  output logic [DIM_W-1:0]          inner_dim,
  output logic [1:0]                status_code,
  output logic                      last_result
);

  // Token path from the classifier to the execution stage.
  logic       tok_valid;
  token_t     tok;
  logic       tok_pop;

  // Result path from the execution stage to the result queue.
  logic [1:0] wr_count;
  result_t    wr_data0;
  result_t    wr_data1;
  result_t    head;
  outq_stat_t outq_stat;

  // Classify each byte and hold it in a short token queue, so the front keeps
  // taking transactions while the back waits for room in the result queue.
  amtp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_pop      (tok_pop)
  );

  // Advance the parser by one token per cycle while the result queue has room; emit up to two results.
  amtp_exec #(
    .CHAR_LIMIT (CHAR_LIMIT)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .outq_stat (outq_stat),
    .wr_count  (wr_count),
    .wr_data0  (wr_data0),
    .wr_data1  (wr_data1)
  );

  // Hold results until the consumer pops them; this is the output register
  // stage that parts the two sides.
  amtp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1),
    .pop      (pop),
    .empty    (empty),
    .rd_data  (head),
    .stat     (outq_stat)
  );

  // Unpack the head of the result queue onto the ports.
  assign result_kind   = head.kind;
  assign matrix_select = head.mat;
  assign row_index     = head.row;
  assign col_index     = head.col;
  assign elem_value    = $signed(head.value);
  assign inner_dim     = head.inner;
  assign status_code   = head.status;
  assign last_result   = head.last;

  // The back stage only takes a token with room for two results.
  `AMTP_ASSERT_IMPLIES(a_exec_room, clk, rst, tok_pop,
    outq_stat.level <= ($clog2(OUTQ_DEPTH)+1)'(OUTQ_DEPTH - 2),
    "token taken without room for two results")

  // A status report always closes its transaction.
  `AMTP_ASSERT_IMPLIES(a_status_last, clk, rst, !empty && result_kind == RK_STATUS,
    last_result, "status report not marked last")

  // A non-final result is always queued together with the report behind it.
  `AMTP_ASSERT_IMPLIES(a_pair_whole, clk, rst, !empty && !last_result,
    outq_stat.level >= ($clog2(OUTQ_DEPTH)+1)'(2), "result pair split in queue")

  // Two writes in a cycle come only from an end-of-input token.
  `AMTP_ASSERT_NEVER(a_pair_source, clk, rst, wr_count == 2'd2 && tok.kind != TOK_END,
    "two results from a character token")

endmodule
